### rtl/particle_motion_step_top_defines.svh
// Assertion helpers shared by the particle step RTL.
`ifndef PARTICLE_MOTION_STEP_TOP_DEFINES_SVH
`define PARTICLE_MOTION_STEP_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PMS_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of a module.
`define PMS_ASSERT(lbl, prop, msg) `PMS_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/pms_pkg.sv
`default_nettype none

package pms_pkg;

  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 600;

  localparam int SPEED_NUM = 204800;
  localparam logic [16:0] LIFE_DECAY = 17'd131;
  localparam logic signed [17:0] NEG_BOUNCE = -18'sd52429;

  // Square root of a 49-bit sum, padded to an even width.
  localparam int SQ_IN_W  = 50;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // Rounded divide of |d| * SPEED_NUM by the root.
  localparam int DIV_NUM_W  = 42;
  localparam int DIV_DEN_W  = SQ_OUT_W;
  localparam int DIV_Q_W    = 18;
  localparam int DIV_STAGES = DIV_Q_W + 1;

  typedef enum logic {
    MODE_FALL = 1'b0,
    MODE_PATH = 1'b1
  } motion_e;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_TSTEP = 3'd1,
    CFG_PLEN  = 3'd2,
    CFG_WP0   = 3'd3,
    CFG_WP1   = 3'd4,
    CFG_WP2   = 3'd5,
    CFG_WP3   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    motion_e            mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [13:0]        im;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
  } s1_t;

  typedef struct packed {
    motion_e            mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [13:0]        im;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic signed [32:0] gx;
    logic signed [32:0] gy;
    logic [47:0]        dxsq;
    logic [47:0]        dysq;
    logic [DIV_NUM_W-1:0] nmx;
    logic [DIV_NUM_W-1:0] nmy;
    logic               sx;
    logic               sy;
  } s2_t;

  typedef struct packed {
    motion_e            mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic signed [47:0] pgx;
    logic signed [47:0] pgy;
    logic [DIV_NUM_W-1:0] nmx;
    logic [DIV_NUM_W-1:0] nmy;
    logic               sx;
    logic               sy;
    logic               far;
  } side_t;

  typedef struct packed {
    motion_e            mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
  } move_in_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic               expired;
  } move_out_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] res;
    if (v > 32'sd8388607) begin
      res = 24'sd8388607;
    end else if (v < -32'sd8388608) begin
      res = -24'sd8388608;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

  // (idx + 1) mod length, with a length of zero taken as one and above four as four.
  function automatic logic [1:0] next_idx(input logic [1:0] idx, input logic [2:0] plen);
    logic [2:0] nxt;
    logic [1:0] res;
    nxt = {1'b0, idx} + 3'd1;
    unique case (plen)
      3'd0, 3'd1: res = 2'd0;
      3'd2:       res = {1'b0, nxt[0]};
      3'd3:       res = (nxt >= 3'd3) ? 2'(nxt - 3'd3) : nxt[1:0];
      default:    res = nxt[1:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/pms_isqrt.sv
`default_nettype none

// Fully pipelined integer square root, one result bit per stage.
module pms_isqrt (
  input  wire logic                         clk_i,
  input  wire logic [pms_pkg::SQ_IN_W-1:0]  rad_i,
  output logic      [pms_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int IW = pms_pkg::SQ_IN_W;
  localparam int N  = pms_pkg::SQ_OUT_W;
  localparam int RW = N + 1;
  localparam int CW = N + 3;

  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [IW-1:0] x_q    [N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [IW-1:0] x_in;
    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cur   = {rem_in, x_in[IW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;

    always_ff @(posedge clk_i) begin
      if (cur >= trial) begin
        rem_q[i]  <= diff[RW-1:0];
        root_q[i] <= {root_in[N-2:0], 1'b1};
      end else begin
        rem_q[i]  <= cur[RW-1:0];
        root_q[i] <= {root_in[N-2:0], 1'b0};
      end
    end

    if (i < N - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        x_q[i] <= {x_in[IW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

### rtl/pms_div.sv
`default_nettype none

// Pipelined restoring divide with round-half-up: quo = (num + den/2) / den.
// The quotient must fit in DIV_Q_W bits; otherwise the result is meaningless.
module pms_div (
  input  wire logic                           clk_i,
  input  wire logic [pms_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire logic [pms_pkg::DIV_DEN_W-1:0]  den_i,
  output logic      [pms_pkg::DIV_Q_W-1:0]    quo_o
);

  localparam int QW = pms_pkg::DIV_Q_W;
  localparam int DW = pms_pkg::DIV_DEN_W;
  localparam int CW = DW + QW;

  logic [CW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= CW'(num_i) + CW'(den_i >> 1);
    den_q[0] <= den_i;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [CW-1:0] shifted;
    logic [QW-1:0] quo_in;
    logic          hit;

    assign shifted = CW'(den_q[k-1]) << B;
    assign hit     = (rem_q[k-1] >= shifted);

    if (k == 1) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[k-2];
    end

    always_ff @(posedge clk_i) begin
      quo_q[k-1] <= quo_in | (QW'(hit) << B);
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= hit ? (rem_q[k-1] - shifted) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire

### rtl/pms_move.sv
`default_nettype none
`include "particle_motion_step_top_defines.svh"

// Moves the particle and decays its life, then bounces it off the screen walls in gravity mode.
module pms_move #(
  parameter int SCREEN_WIDTH  = pms_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pms_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               vld_i,
  input  wire pms_pkg::move_in_t  in_i,
  input  wire logic [15:0]        tstep_i,
  output logic                    vld_o,
  output pms_pkg::move_out_t      out_o
);

  localparam logic signed [25:0] LIM_X = 26'(SCREEN_WIDTH * 4096);
  localparam logic signed [25:0] LIM_Y = 26'(SCREEN_HEIGHT * 4096);

  typedef struct packed {
    pms_pkg::motion_e   mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic signed [40:0] pvx;
    logic signed [40:0] pvy;
    logic signed [41:0] bvx;
    logic signed [41:0] bvy;
  } m1_t;

  typedef struct packed {
    pms_pkg::motion_e   mode;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vbx;
    logic signed [23:0] vby;
    logic [15:0]        r;
    logic [16:0]        life;
    logic [1:0]         idx;
  } m2_t;

  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  pms_pkg::move_out_t out_d, out_q;
  pms_pkg::motion_e   mode3_q;
  logic vld1_q, vld2_q, vld3_q;

  logic signed [25:0] p26x, p26y, r26;

  // Products: displacement and the bounced velocity, both taken in parallel.
  always_comb begin
    m1_d.mode = in_i.mode;
    m1_d.px   = in_i.px;
    m1_d.py   = in_i.py;
    m1_d.vx   = in_i.vx;
    m1_d.vy   = in_i.vy;
    m1_d.r    = in_i.r;
    m1_d.idx  = in_i.idx;
    m1_d.life = (in_i.life > pms_pkg::LIFE_DECAY) ? (in_i.life - pms_pkg::LIFE_DECAY) : '0;
    m1_d.pvx  = in_i.vx * $signed({1'b0, tstep_i});
    m1_d.pvy  = in_i.vy * $signed({1'b0, tstep_i});
    m1_d.bvx  = in_i.vx * pms_pkg::NEG_BOUNCE;
    m1_d.bvy  = in_i.vy * pms_pkg::NEG_BOUNCE;
  end

  always_comb begin
    m2_d.mode = m1_q.mode;
    m2_d.vx   = m1_q.vx;
    m2_d.vy   = m1_q.vy;
    m2_d.r    = m1_q.r;
    m2_d.life = m1_q.life;
    m2_d.idx  = m1_q.idx;
    m2_d.px   = pms_pkg::sat24(32'((m1_q.pvx + 41'sd2048) >>> 12) + 32'(m1_q.px));
    m2_d.py   = pms_pkg::sat24(32'((m1_q.pvy + 41'sd2048) >>> 12) + 32'(m1_q.py));
    m2_d.vbx  = pms_pkg::sat24(32'((m1_q.bvx + 42'sd32768) >>> 16));
    m2_d.vby  = pms_pkg::sat24(32'((m1_q.bvy + 42'sd32768) >>> 16));
  end

  // Walls: the low-side clamp is checked first and wins.
  always_comb begin
    p26x = 26'(m2_q.px);
    p26y = 26'(m2_q.py);
    r26  = $signed({10'b0, m2_q.r});

    out_d.life    = m2_q.life;
    out_d.idx     = m2_q.idx;
    out_d.expired = (m2_q.life == '0);

    priority if (m2_q.mode == pms_pkg::MODE_FALL && p26x < r26) begin
      out_d.px = 24'(r26);
      out_d.vx = m2_q.vbx;
    end else if (m2_q.mode == pms_pkg::MODE_FALL && (p26x + r26) > LIM_X) begin
      out_d.px = 24'(LIM_X - r26);
      out_d.vx = m2_q.vbx;
    end else begin
      out_d.px = m2_q.px;
      out_d.vx = m2_q.vx;
    end

    priority if (m2_q.mode == pms_pkg::MODE_FALL && p26y < r26) begin
      out_d.py = 24'(r26);
      out_d.vy = m2_q.vby;
    end else if (m2_q.mode == pms_pkg::MODE_FALL && (p26y + r26) > LIM_Y) begin
      out_d.py = 24'(LIM_Y - r26);
      out_d.vy = m2_q.vby;
    end else begin
      out_d.py = m2_q.py;
      out_d.vy = m2_q.vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    out_q   <= out_d;
    mode3_q <= m2_q.mode;
  end

  assign vld_o = vld3_q;
  assign out_o = out_q;

  `PMS_ASSERT(a_wall_x_low, (vld3_q && mode3_q == pms_pkg::MODE_FALL) |-> !out_q.px[23], "x left of wall after bounce")
  `PMS_ASSERT(a_wall_y_low, (vld3_q && mode3_q == pms_pkg::MODE_FALL) |-> !out_q.py[23], "y above wall after bounce")
  `PMS_ASSERT(a_expired, vld3_q |-> (out_q.expired == (out_q.life == '0)), "expired flag disagrees with life")

endmodule

`default_nettype wire

### rtl/particle_motion_step_top.sv
`default_nettype none
`include "particle_motion_step_top_defines.svh"

// Particle step engine. One particle item is taken on every clock where start_i is
// high and busy_o is low; busy_o is high only in the first cycle after reset, so a
// new item can follow in every cycle. Each item gives exactly one result, shown for
// a single cycle with done_o; results come out in order and cannot be held off.
// Every item passes the waypoint steering path: a 25-stage square root of the
// squared distance followed by a 19-stage rounded divide, with three entry stages
// ahead and four select, move and wall stages after. Gravity items take the same
// path and the same latency. Registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; mode and waypoints are read as an item is taken, time step and path
// length later on its way; write them only while no item is in flight.
module particle_motion_step_top #(
  parameter int SCREEN_WIDTH  = pms_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pms_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [19:0]        cfg_wdata_i,

  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] vel_x_i,
  input  wire logic signed [23:0] vel_y_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic [13:0]        inverse_mass_i,
  input  wire logic [15:0]        particle_radius_i,
  input  wire logic [16:0]        life_left_i,
  input  wire logic [1:0]         waypoint_index_i,

  output logic                    done_o,
  output logic signed [23:0]      new_pos_x_o,
  output logic signed [23:0]      new_pos_y_o,
  output logic signed [23:0]      new_vel_x_o,
  output logic signed [23:0]      new_vel_y_o,
  output logic [16:0]             new_life_o,
  output logic [1:0]              new_waypoint_index_o,
  output logic                    expired_o
);

  localparam int DLY = pms_pkg::SQ_OUT_W + pms_pkg::DIV_STAGES;
  localparam int LAT = 3 + DLY + 4;

  // Configuration registers.
  pms_pkg::motion_e mode_q;
  logic [15:0]      tstep_q;
  logic [2:0]       plen_q;
  logic [19:0]      wp_q [4];
  logic             busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pms_pkg::MODE_FALL;
      tstep_q <= 16'd4096;
      plen_q  <= 3'd4;
      wp_q[0] <= 20'd102500;
      wp_q[1] <= 20'd103100;
      wp_q[2] <= 20'd512700;
      wp_q[3] <= 20'd512100;
    end else if (cfg_we_i) begin
      unique case (pms_pkg::cfg_idx_e'(cfg_idx_i))
        pms_pkg::CFG_MODE:  mode_q  <= pms_pkg::motion_e'(cfg_wdata_i[0]);
        pms_pkg::CFG_TSTEP: tstep_q <= cfg_wdata_i[15:0];
        pms_pkg::CFG_PLEN:  plen_q  <= cfg_wdata_i[2:0];
        pms_pkg::CFG_WP0:   wp_q[0] <= cfg_wdata_i;
        pms_pkg::CFG_WP1:   wp_q[1] <= cfg_wdata_i;
        pms_pkg::CFG_WP2:   wp_q[2] <= cfg_wdata_i;
        pms_pkg::CFG_WP3:   wp_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  logic in_acc;
  assign in_acc = start_i && !busy_q;

  // Entry stages.
  pms_pkg::s1_t   s1_d, s1_q;
  pms_pkg::s2_t   s2_d, s2_q;
  pms_pkg::side_t s3_d, s3_q;
  logic [48:0]    sum_d, sum_q;
  logic           vld1_q, vld2_q, vld3_q;

  logic [19:0] wp_sel;
  logic [21:0] tx, ty;

  always_comb begin
    wp_sel = wp_q[waypoint_index_i];
    tx     = {wp_sel[9:0], 12'd0};
    ty     = {wp_sel[19:10], 12'd0};

    s1_d.mode = mode_q;
    s1_d.px   = pos_x_i;
    s1_d.py   = pos_y_i;
    s1_d.vx   = vel_x_i;
    s1_d.vy   = vel_y_i;
    s1_d.ax   = accel_x_i;
    s1_d.ay   = accel_y_i;
    s1_d.im   = inverse_mass_i;
    s1_d.r    = particle_radius_i;
    s1_d.life = life_left_i;
    s1_d.idx  = waypoint_index_i;
    s1_d.dx   = $signed({3'b000, tx}) - $signed({pos_x_i[23], pos_x_i});
    s1_d.dy   = $signed({3'b000, ty}) - $signed({pos_y_i[23], pos_y_i});
  end

  logic signed [49:0] dxsq_w, dysq_w;
  logic signed [24:0] absx, absy;

  always_comb begin
    dxsq_w = s1_q.dx * s1_q.dx;
    dysq_w = s1_q.dy * s1_q.dy;
    absx   = s1_q.dx[24] ? -s1_q.dx : s1_q.dx;
    absy   = s1_q.dy[24] ? -s1_q.dy : s1_q.dy;

    s2_d.mode = s1_q.mode;
    s2_d.px   = s1_q.px;
    s2_d.py   = s1_q.py;
    s2_d.vx   = s1_q.vx;
    s2_d.vy   = s1_q.vy;
    s2_d.im   = s1_q.im;
    s2_d.r    = s1_q.r;
    s2_d.life = s1_q.life;
    s2_d.idx  = s1_q.idx;
    s2_d.gx   = s1_q.ax * $signed({1'b0, tstep_q});
    s2_d.gy   = s1_q.ay * $signed({1'b0, tstep_q});
    s2_d.dxsq = dxsq_w[47:0];
    s2_d.dysq = dysq_w[47:0];
    s2_d.nmx  = pms_pkg::DIV_NUM_W'(absx[23:0]) * pms_pkg::DIV_NUM_W'(pms_pkg::SPEED_NUM);
    s2_d.nmy  = pms_pkg::DIV_NUM_W'(absy[23:0]) * pms_pkg::DIV_NUM_W'(pms_pkg::SPEED_NUM);
    s2_d.sx   = s1_q.dx[24];
    s2_d.sy   = s1_q.dy[24];
  end

  always_comb begin
    sum_d = {1'b0, s2_q.dxsq} + {1'b0, s2_q.dysq};

    s3_d.mode = s2_q.mode;
    s3_d.px   = s2_q.px;
    s3_d.py   = s2_q.py;
    s3_d.vx   = s2_q.vx;
    s3_d.vy   = s2_q.vy;
    s3_d.r    = s2_q.r;
    s3_d.life = s2_q.life;
    s3_d.idx  = s2_q.idx;
    s3_d.pgx  = s2_q.gx * $signed({1'b0, s2_q.im});
    s3_d.pgy  = s2_q.gy * $signed({1'b0, s2_q.im});
    s3_d.nmx  = s2_q.nmx;
    s3_d.nmy  = s2_q.nmy;
    s3_d.sx   = s2_q.sx;
    s3_d.sy   = s2_q.sy;
    // Steering applies only when more than one pixel from the waypoint.
    s3_d.far  = (sum_d > (49'd1 << 24));
  end

  // Side data waits here while the root and the quotients are worked out.
  pms_pkg::side_t side_q [DLY];
  logic [DLY-1:0] vdly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vdly_q <= '0;
    end else begin
      vld1_q <= in_acc;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vdly_q <= {vdly_q[DLY-2:0], vld3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    s2_q      <= s2_d;
    s3_q      <= s3_d;
    sum_q     <= sum_d;
    side_q[0] <= s3_q;
    for (int k = 1; k < DLY; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic [pms_pkg::SQ_OUT_W-1:0] root;
  logic [pms_pkg::DIV_Q_W-1:0]  qx, qy;

  pms_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  ({1'b0, sum_q}),
    .root_o (root)
  );

  pms_div u_div_x (
    .clk_i (clk_i),
    .num_i (side_q[pms_pkg::SQ_OUT_W-1].nmx),
    .den_i (root),
    .quo_o (qx)
  );

  pms_div u_div_y (
    .clk_i (clk_i),
    .num_i (side_q[pms_pkg::SQ_OUT_W-1].nmy),
    .den_i (root),
    .quo_o (qy)
  );

  // Velocity select: gravity update, waypoint steering, or keep and advance index.
  pms_pkg::side_t    sd;
  pms_pkg::move_in_t sel_d, sel_q;
  logic              vsel_q, sel_far_q;
  logic signed [47:0] rgx, rgy;
  logic signed [31:0] wvx, wvy;

  always_comb begin
    sd  = side_q[DLY-1];
    rgx = (sd.pgx + (48'sd1 <<< 23)) >>> 24;
    rgy = (sd.pgy + (48'sd1 <<< 23)) >>> 24;
    wvx = sd.sx ? -$signed({14'b0, qx}) : $signed({14'b0, qx});
    wvy = sd.sy ? -$signed({14'b0, qy}) : $signed({14'b0, qy});

    sel_d.mode = sd.mode;
    sel_d.px   = sd.px;
    sel_d.py   = sd.py;
    sel_d.r    = sd.r;
    sel_d.life = sd.life;

    priority if (sd.mode == pms_pkg::MODE_FALL) begin
      sel_d.vx  = pms_pkg::sat24(32'(sd.vx) + 32'(rgx));
      sel_d.vy  = pms_pkg::sat24(32'(sd.vy) + 32'(rgy));
      sel_d.idx = sd.idx;
    end else if (sd.far) begin
      sel_d.vx  = pms_pkg::sat24(wvx);
      sel_d.vy  = pms_pkg::sat24(wvy);
      sel_d.idx = sd.idx;
    end else begin
      sel_d.vx  = sd.vx;
      sel_d.vy  = sd.vy;
      sel_d.idx = pms_pkg::next_idx(sd.idx, plen_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsel_q <= 1'b0;
    end else begin
      vsel_q <= vdly_q[DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    sel_far_q <= sd.far;
  end

  pms_pkg::move_out_t mv_out;
  logic               mv_vld;

  pms_move #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_move (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vsel_q),
    .in_i    (sel_q),
    .tstep_i (tstep_q),
    .vld_o   (mv_vld),
    .out_o   (mv_out)
  );

  assign done_o               = mv_vld;
  assign new_pos_x_o          = mv_out.px;
  assign new_pos_y_o          = mv_out.py;
  assign new_vel_x_o          = mv_out.vx;
  assign new_vel_y_o          = mv_out.vy;
  assign new_life_o           = mv_out.life;
  assign new_waypoint_index_o = mv_out.idx;
  assign expired_o            = mv_out.expired;

  `PMS_ASSERT(a_latency, done_o |-> $past(start_i && !busy_o, LAT), "result without a matching item")
  `PMS_ASSERT(a_steer_speed, (vsel_q && sel_q.mode == pms_pkg::MODE_PATH && sel_far_q) |-> (sel_q.vx <= 24'sd204800 && sel_q.vx >= -24'sd204800), "steering speed out of range")
  `PMS_ASSERT(a_busy_once, !$rose(busy_o), "busy raised after reset")

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES = 8;

  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [13:0]        recip_mass;
    logic [15:0]        radius;
    logic [16:0]        life;
    logic [1:0]         idx;
  } particle_t;

  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [16:0]        life;
    logic [1:0]         idx;
    logic               expired;
  } motion_t;

  typedef struct {
    pms_pkg::motion_e mode;
    logic [15:0]      tstep;
    logic [2:0]       plen;
    logic [19:0]      wp[4];
  } setup_t;

  class motion_scoreboard;
    motion_t expected_motion[$];
    int      errors;
    int      checked;

    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint div_near(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void wall(inout longint p, inout longint v, input longint r, input longint lim);
      if (p < r) begin
        p = r;
        v = clip24(rnd_shift(-v * 52429, 16));
      end else if (p + r > lim) begin
        p = lim - r;
        v = clip24(rnd_shift(-v * 52429, 16));
      end
    endfunction

    function void note(particle_t p, setup_t c);
      longint px, py, vx, vy, ax, ay, im, r, dt, tx, ty, dx, dy;
      longint unsigned sum, s;
      logic [1:0] idx;
      logic [16:0] lf;
      int len;
      motion_t m;
      px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
      ax = p.accel_x; ay = p.accel_y;
      im = longint'(p.recip_mass); r = longint'(p.radius);
      dt = longint'(c.tstep); idx = p.idx;
      if (c.mode == pms_pkg::MODE_FALL) begin
        vx = clip24(vx + rnd_shift(ax * dt * im, 24));
        vy = clip24(vy + rnd_shift(ay * dt * im, 24));
      end else begin
        tx = longint'(c.wp[idx][9:0]) << 12;
        ty = longint'(c.wp[idx][19:10]) << 12;
        dx = tx - px;
        dy = ty - py;
        sum = dx * dx + dy * dy;
        if (sum > (64'd1 << 24)) begin
          s = int_sqrt(sum);
          vx = clip24(div_near(dx * 204800, s));
          vy = clip24(div_near(dy * 204800, s));
        end else begin
          len = c.plen;
          if (len == 0) len = 1;
          if (len > 4) len = 4;
          idx = 2'((int'(idx) + 1) % len);
        end
      end
      px = clip24(px + rnd_shift(vx * dt, 12));
      py = clip24(py + rnd_shift(vy * dt, 12));
      if (c.mode == pms_pkg::MODE_FALL) begin
        wall(px, vx, r, longint'(800) * 4096);
        wall(py, vy, r, longint'(600) * 4096);
      end
      lf = (p.life > 17'd131) ? p.life - 17'd131 : 17'd0;
      m.pos_x = px[23:0]; m.pos_y = py[23:0];
      m.vel_x = vx[23:0]; m.vel_y = vy[23:0];
      m.life = lf; m.idx = idx; m.expired = (lf == 0);
      expected_motion.push_back(m);
    endfunction

    task report(string field, longint got, longint exp);
      errors++;
      $display("MISMATCH result %0d %s: got %0d expected %0d", checked, field, got, exp);
    endtask

    task check(motion_t got);
      motion_t e;
      if (expected_motion.size() == 0) begin
        report("result with nothing outstanding", 1, 0);
        return;
      end
      e = expected_motion.pop_front();
      if (got.pos_x !== e.pos_x) report("new_pos_x", got.pos_x, e.pos_x);
      if (got.pos_y !== e.pos_y) report("new_pos_y", got.pos_y, e.pos_y);
      if (got.vel_x !== e.vel_x) report("new_vel_x", got.vel_x, e.vel_x);
      if (got.vel_y !== e.vel_y) report("new_vel_y", got.vel_y, e.vel_y);
      if (got.life !== e.life) report("new_life", got.life, e.life);
      if (got.idx !== e.idx) report("new_waypoint_index", got.idx, e.idx);
      if (got.expired !== e.expired) report("expired", got.expired, e.expired);
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [19:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [23:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0;
  logic [13:0] inverse_mass_i = '0;
  logic [15:0] particle_radius_i = '0;
  logic [16:0] life_left_i = '0;
  logic [1:0] waypoint_index_i = '0;
  logic done_o;
  logic signed [23:0] new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;
  logic [16:0] new_life_o;
  logic [1:0] new_waypoint_index_o;
  logic expired_o;

  particle_motion_step_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  motion_scoreboard sb;
  setup_t setup;
  int n_sent;
  int quiet = 0;

  always @(posedge clk_i) begin
    motion_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.pos_x = new_pos_x_o; got.pos_y = new_pos_y_o;
      got.vel_x = new_vel_x_o; got.vel_y = new_vel_y_o;
      got.life = new_life_o; got.idx = new_waypoint_index_o; got.expired = expired_o;
      sb.check(got);
    end
  end

  // The watchdog is restarted by any accepted item or result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no activity for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(pms_pkg::cfg_idx_e idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      pms_pkg::CFG_MODE:  setup.mode = pms_pkg::motion_e'(val[0]);
      pms_pkg::CFG_TSTEP: setup.tstep = val[15:0];
      pms_pkg::CFG_PLEN:  setup.plen = val[2:0];
      default:            setup.wp[int'(idx) - int'(pms_pkg::CFG_WP0)] = val;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send(particle_t p);
    @(negedge clk_i);
    pos_x_i = p.pos_x; pos_y_i = p.pos_y; vel_x_i = p.vel_x; vel_y_i = p.vel_y;
    accel_x_i = p.accel_x; accel_y_i = p.accel_y; inverse_mass_i = p.recip_mass;
    particle_radius_i = p.radius; life_left_i = p.life; waypoint_index_i = p.idx;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note(p, setup);
    n_sent++;
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_motion.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic particle_t mk(int px, int py, int vx, int vy, int ax, int ay,
                                   int im, int r, int lf, int idx);
    particle_t p;
    p.pos_x = 24'(px); p.pos_y = 24'(py); p.vel_x = 24'(vx); p.vel_y = 24'(vy);
    p.accel_x = 16'(ax); p.accel_y = 16'(ay); p.recip_mass = 14'(im);
    p.radius = 16'(r); p.life = 17'(lf); p.idx = 2'(idx);
    return p;
  endfunction

  function automatic int spread(int v);
    return int'($urandom_range(0, 2 * v)) - v;
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int k;
    logic [19:0] wp;
    p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom);
    k = $urandom_range(0, 9);
    if (k >= 2) begin
      p.pos_x = 24'(int'($urandom_range(0, 800 * 4096)));
      p.pos_y = 24'(int'($urandom_range(0, 600 * 4096)));
      p.vel_x = 24'(spread(64 * 4096));
      p.vel_y = 24'(spread(64 * 4096));
      p.life = 17'($urandom_range(0, 65536));
      if (setup.mode == pms_pkg::MODE_PATH && k < 7) begin
        // Land near the waypoint so that some items fall within one pixel.
        wp = setup.wp[p.idx];
        p.pos_x = 24'((int'(wp[9:0]) << 12) + spread(6000));
        p.pos_y = 24'((int'(wp[19:10]) << 12) + spread(6000));
      end
    end
    return p;
  endfunction

  task automatic directed_gravity();
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(8388607, 8388607, 8388607, 8388607, 32767, 32767, 16383, 65535, 65536, 3));
    send(mk(-8388608, -8388608, -8388608, -8388608, -32768, -32768, 16383, 65535,
            131071, 2));
    send(mk(4096, 300 << 12, -5 << 12, 0, -32768, 0, 4096, 8192, 131, 1));
    send(mk(799 << 12, 300 << 12, 9 << 12, 0, 32767, 0, 4096, 16384, 132, 0));
    send(mk(400 << 12, 4096, 0, -7 << 12, 0, -20000, 8192, 4096, 1, 0));
    send(mk(400 << 12, 599 << 12, 0, 7 << 12, 0, 20000, 8192, 40000, 65536, 0));
    send(mk(2048, 598 << 12, -8388608, 8388607, 0, 0, 0, 65535, 100000, 1));
    send(mk(400 << 12, 300 << 12, 3 << 12, -2 << 12, 4096, 4096, 4096, 4096, 30000, 2));
    send(mk(-4096, 900 << 12, 0, 0, 0, 0, 0, 0, 200, 3));
  endtask

  task automatic directed_path();
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 65536, 0));
    send(mk(100 << 12, 100 << 12, 5, 5, 0, 0, 0, 0, 500, 0));
    send(mk((700 << 12) + 2000, (100 << 12) - 2000, 1, 1, 0, 0, 0, 0, 500, 1));
    send(mk((700 << 12) + 4096, 500 << 12, 0, 0, 0, 0, 0, 0, 131, 2));
    send(mk((100 << 12) + 4097, 500 << 12, 0, 0, 0, 0, 0, 0, 131071, 3));
    send(mk(-8388608, 8388607, 0, 0, 0, 0, 0, 0, 0, 3));
    send(mk(8388607, -8388608, 0, 0, 0, 0, 0, 0, 40, 1));
  endtask

  task automatic setup_phase(int ph);
    case (ph)
      0: begin
        write_reg(pms_pkg::CFG_MODE, pms_pkg::MODE_FALL);
      end
      1: write_reg(pms_pkg::CFG_TSTEP, 20'hFFFF);
      2: write_reg(pms_pkg::CFG_TSTEP, 20'h0);
      3: write_reg(pms_pkg::CFG_TSTEP, 20'($urandom_range(0, 16384)));
      4: begin
        write_reg(pms_pkg::CFG_MODE, pms_pkg::MODE_PATH);
        write_reg(pms_pkg::CFG_TSTEP, 20'd4096);
        write_reg(pms_pkg::CFG_PLEN, 20'd4);
        write_reg(pms_pkg::CFG_WP0, 20'd102500);
        write_reg(pms_pkg::CFG_WP1, 20'd103100);
        write_reg(pms_pkg::CFG_WP2, 20'd512700);
        write_reg(pms_pkg::CFG_WP3, 20'd512100);
      end
      5: begin
        write_reg(pms_pkg::CFG_PLEN, 20'd0);
        write_reg(pms_pkg::CFG_WP2, 20'($urandom));
        write_reg(pms_pkg::CFG_WP3, 20'($urandom));
      end
      6: begin
        write_reg(pms_pkg::CFG_PLEN, 20'd7);
        write_reg(pms_pkg::CFG_WP0, 20'hFFFFF);
        write_reg(pms_pkg::CFG_WP1, 20'h0);
        write_reg(pms_pkg::CFG_TSTEP, 20'hFFFF);
      end
      default: begin
        write_reg(pms_pkg::CFG_PLEN, 20'($urandom_range(1, 3)));
        write_reg(pms_pkg::CFG_TSTEP, 20'($urandom_range(0, 65535)));
        write_reg(pms_pkg::CFG_WP0, 20'($urandom));
      end
    endcase
    end_writes();
  endtask

  initial begin
    bit idling;
    sb = new();
    setup.mode = pms_pkg::MODE_FALL;
    setup.tstep = 16'd4096;
    setup.plen = 3'd4;
    setup.wp[0] = 20'd102500;
    setup.wp[1] = 20'd103100;
    setup.wp[2] = 20'd512700;
    setup.wp[3] = 20'd512100;
    n_sent = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setup_phase(ph);
      if (ph == 0) directed_gravity();
      if (ph == 4) directed_path();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send(rand_particle());
        if (ph == 3 && i == 20) begin
          // Hold the sender until the pipeline has emptied completely.
          @(negedge clk_i);
          start_i = 1'b0;
          while (sb.expected_motion.size() != 0) @(posedge clk_i);
        end
        idling = (ph < NUM_PHASES - 1) && (i % 40 < 25);
        if (idling && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
      end
      drain();
    end
    $display("sent %0d particle items over %0d register settings, %0d results checked",
             n_sent, NUM_PHASES, sb.checked);
    $display("covered gravity with wall bounce and waypoint steering with index advance");
    if (sb.errors == 0 && sb.expected_motion.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
